@@ src/mfvf_pkg.sv @@
// shared types and sizing constants for the most frequent value finder
// depends on nothing; imported by most_frequent_value_finder_core
package mfvf_pkg;

	localparam int MAX_ITEMS = 1024;
	localparam int ADDR_W    = $clog2(MAX_ITEMS);
	localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
	localparam int VALUE_W   = 32;
	localparam int OUT_CNT_W = 11;
	localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX = '1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sample_value;
		logic                      last_item;
	} in_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] mode_value;
		logic [OUT_CNT_W-1:0]      mode_count;
		logic                      all_equal;
		logic                      overflow;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_LOAD     = 4'b0001,
		ST_OUTER_RD = 4'b0010,
		ST_OUTER_LT = 4'b0100,
		ST_INNER    = 4'b1000
	} state_t;

endpackage

@@ src/most_frequent_value_finder_core.sv @@
// top level of the most frequent value finder: value store, sequencer, counter
// depends on mfvf_pkg
//
// usage
//   input words arrive on sample while start is high and busy is low; each word
//   holds one signed value and a last_item flag. words are stored in a
//   MAX_ITEMS deep memory; words beyond that are dropped and flag overflow.
//   a word with last_item set starts the count. for each stored entry the
//   sequencer reads it once, then sweeps the whole store through the single
//   memory read port, one entry a cycle, counting matches in a shared
//   compare and increment unit. when the count ends, done pulses for one
//   cycle with the word on result: the earliest most frequent value, its
//   count, all_equal when highest and lowest counts match, and overflow.
//   the memory read port sets the pace: one compare per cycle. busy stays
//   high for the whole count. the receiver cannot stall: result is valid
//   only while done is high.
//   reset empties the sequence and returns to loading; the value store
//   itself is not cleared, only entries already written are ever read.
//   after each result the block is ready for a new sequence at once.
module most_frequent_value_finder_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  mfvf_pkg::in_word_t   sample,
	output logic                 busy,
	output logic                 done,
	output mfvf_pkg::out_word_t  result
);
	import mfvf_pkg::*;

	logic [VALUE_W-1:0] mem [MAX_ITEMS];

	state_t             state_q;
	logic [CNT_W-1:0]   item_cnt_q;
	logic [ADDR_W-1:0]  outer_q;
	logic [ADDR_W-1:0]  inner_q;
	logic [CNT_W-1:0]   running_q;
	logic [CNT_W-1:0]   best_q;
	logic [CNT_W-1:0]   least_q;
	logic [VALUE_W-1:0] best_val_q;
	logic               ovf_q;
	logic [VALUE_W-1:0] outer_val_q;
	logic [VALUE_W-1:0] rd_data_q;
	logic               cmp_vld_s1;
	logic               tail_q;
	logic               done_q;
	out_word_t          result_q;

	logic               accept;
	logic               full;
	logic [ADDR_W-1:0]  last_idx;
	logic [ADDR_W-1:0]  rd_addr;
	logic               match;
	logic [CNT_W-1:0]   row_cnt;
	logic               new_best;
	logic [CNT_W-1:0]   best_fin;
	logic [CNT_W-1:0]   least_fin;
	logic [VALUE_W-1:0] best_val_fin;
	logic [31:0]        best_ext;

	assign busy     = (state_q != ST_LOAD);
	assign accept   = start && !busy;
	assign full     = (item_cnt_q == CNT_W'(MAX_ITEMS));
	assign last_idx = ADDR_W'(item_cnt_q - CNT_W'(1));
	assign rd_addr  = (state_q == ST_INNER) ? inner_q : outer_q;

	assign match    = cmp_vld_s1 && (rd_data_q == outer_val_q);
	assign row_cnt  = running_q + CNT_W'(match);
	assign new_best = (row_cnt > best_q);

	assign best_fin     = new_best ? row_cnt : best_q;
	assign best_val_fin = new_best ? outer_val_q : best_val_q;
	assign least_fin    = (row_cnt < least_q) ? row_cnt : least_q;
	assign best_ext     = 32'(best_fin);

	// value store
	always_ff @(posedge clk) begin
		if (accept && !full) begin
			mem[item_cnt_q[ADDR_W-1:0]] <= sample.sample_value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUTER_LT) begin
			outer_val_q <= rd_data_q;
		end
		if (tail_q && outer_q == last_idx) begin
			result_q.mode_value <= best_val_fin;
			result_q.mode_count <= (best_ext > 32'(OUT_CNT_MAX)) ? OUT_CNT_MAX
				: best_ext[OUT_CNT_W-1:0];
			result_q.all_equal  <= (best_fin == least_fin);
			result_q.overflow   <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			item_cnt_q <= '0;
			outer_q    <= '0;
			inner_q    <= '0;
			running_q  <= '0;
			best_q     <= '0;
			least_q    <= '1;
			best_val_q <= '0;
			ovf_q      <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			tail_q     <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= 1'b0;
			cmp_vld_s1 <= (state_q == ST_INNER);
			tail_q     <= 1'b0;

			// shared compare and count unit, one compare per cycle
			if (cmp_vld_s1) begin
				running_q <= row_cnt;
			end

			// row finished: fold its count into best and least; last row pulses done
			if (tail_q) begin
				best_q     <= best_fin;
				least_q    <= least_fin;
				best_val_q <= best_val_fin;
				if (outer_q == last_idx) begin
					done_q     <= 1'b1;
					item_cnt_q <= '0;
					outer_q    <= '0;
					inner_q    <= '0;
					running_q  <= '0;
					best_q     <= '0;
					least_q    <= '1;
					best_val_q <= '0;
					ovf_q      <= 1'b0;
					state_q    <= ST_LOAD;
				end else begin
					outer_q <= outer_q + ADDR_W'(1);
					state_q <= ST_OUTER_RD;
				end
			end

			case (state_q)
				ST_LOAD: begin
					if (accept) begin
						if (full) begin
							ovf_q <= 1'b1;
						end else begin
							item_cnt_q <= item_cnt_q + CNT_W'(1);
						end
						if (sample.last_item) begin
							outer_q <= '0;
							state_q <= ST_OUTER_RD;
						end
					end
				end
				ST_OUTER_RD: begin
					if (!tail_q) begin
						state_q <= ST_OUTER_LT;
					end
				end
				ST_OUTER_LT: begin
					inner_q   <= '0;
					running_q <= '0;
					state_q   <= ST_INNER;
				end
				ST_INNER: begin
					inner_q <= inner_q + ADDR_W'(1);
					if (inner_q == last_idx) begin
						tail_q  <= 1'b1;
						state_q <= ST_OUTER_RD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for most_frequent_value_finder_core: sequences of signed words,
// predicted mode per sequence checked against every done strobe
// depends on mfvf_pkg and most_frequent_value_finder_core

class mode_scoreboard;
	logic [mfvf_pkg::VALUE_W-1:0] stored [mfvf_pkg::MAX_ITEMS];
	int unsigned                  stored_total;
	bit                           dropped_any;
	mfvf_pkg::out_word_t          pending_modes [$];
	int unsigned                  mismatches;

	function void take_sample(mfvf_pkg::in_word_t w);
		mfvf_pkg::out_word_t m;
		int unsigned hits;
		int unsigned best;
		int unsigned least;
		if (stored_total < mfvf_pkg::MAX_ITEMS) begin
			stored[stored_total] = w.sample_value;
			stored_total++;
		end else begin
			dropped_any = 1'b1;
		end
		if (!w.last_item)
			return;
		best = 0;
		least = 32'hFFFF_FFFF;
		m.mode_value = stored[0];
		for (int i = 0; i < stored_total; i++) begin
			hits = 0;
			for (int j = 0; j < stored_total; j++)
				if (stored[i] == stored[j])
					hits++;
			if (hits > best) begin
				best = hits;
				m.mode_value = stored[i];
			end
			if (hits < least)
				least = hits;
		end
		m.mode_count = (best > mfvf_pkg::OUT_CNT_MAX) ? mfvf_pkg::OUT_CNT_MAX
			: best[mfvf_pkg::OUT_CNT_W-1:0];
		m.all_equal = (best == least);
		m.overflow = dropped_any;
		pending_modes.push_back(m);
		stored_total = 0;
		dropped_any = 1'b0;
	endfunction

	function void check_result(mfvf_pkg::out_word_t got);
		mfvf_pkg::out_word_t want;
		if (pending_modes.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: value %0d count %0d all_equal %0b overflow %0b",
					got.mode_value, got.mode_count, got.all_equal, got.overflow);
			return;
		end
		want = pending_modes.pop_front();
		if (got.mode_value !== want.mode_value || got.mode_count !== want.mode_count ||
				got.all_equal !== want.all_equal || got.overflow !== want.overflow) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mode mismatch: want %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
					want.mode_value, want.mode_count, want.all_equal, want.overflow,
					got.mode_value, got.mode_count, got.all_equal, got.overflow);
		end
	endfunction
endclass

module tb_top;
	import mfvf_pkg::*;

	// longest quiet stretch is a full count over MAX_ITEMS entries
	localparam int unsigned IDLE_LIMIT = 4 * MAX_ITEMS * (MAX_ITEMS + 3) + 1000;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      start;
	in_word_t  sample;
	logic      busy;
	logic      done;
	out_word_t result;

	mode_scoreboard sb;
	int unsigned    words_taken;
	int unsigned    quiet_cycles;
	int unsigned    words_sent;
	int unsigned    burst_left;

	most_frequent_value_finder_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sample (sample),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.take_sample(sample);
				words_taken++;
			end
			if (done)
				sb.check_result(result);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("tb_top: errors");
				$finish;
			end
		end
	end

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			4: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic [31:0] v, input bit last);
		int unsigned seen;
		if (burst_left == 0) begin
			start <= 1'b0;
			repeat (($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 4))
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
		end
		seen = words_taken;
		start <= 1'b1;
		sample <= '{sample_value: v, last_item: last};
		do @(negedge clk); while (words_taken == seen);
		burst_left--;
	endtask

	task automatic send_sequence(input logic [31:0] seq [$]);
		foreach (seq[i])
			send_word(seq[i], i == seq.size() - 1);
		words_sent += seq.size();
	endtask

	task automatic random_sequence();
		logic [31:0] pool [5];
		logic [31:0] seq [$];
		int unsigned len;
		int unsigned pool_n;
		int unsigned r;
		bit          scattered;
		r = $urandom_range(0, 19);
		len = (r < 17) ? $urandom_range(1, 12) :
			(r < 19) ? $urandom_range(13, 40) : $urandom_range(41, 64);
		pool_n = $urandom_range(1, 5);
		scattered = ($urandom_range(0, 4) == 0);
		foreach (pool[i])
			pool[i] = pick_value();
		repeat (len)
			seq.push_back(((scattered ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 4) == 0)))
				? pick_value() : pool[$urandom_range(0, pool_n - 1)]);
		send_sequence(seq);
	endtask

	initial begin
		logic [31:0] seq [$];
		int unsigned target;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		words_taken = 0;
		quiet_cycles = 0;
		words_sent = 0;
		burst_left = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single word
		seq = '{32'h8000_0000};
		send_sequence(seq);
		// all distinct, extremes
		seq = '{32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000};
		send_sequence(seq);
		// even tie, no unique mode
		seq = '{32'd5, 32'd5, 32'd7, 32'd7};
		send_sequence(seq);
		// tie at the top, earliest wins
		seq = '{32'd9, 32'd1, 32'd1, 32'd9, 32'd2};
		send_sequence(seq);
		seq = '{32'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd3};
		send_sequence(seq);
		seq = '{32'd0, 32'd0, 32'd0};
		send_sequence(seq);
		// full store, then a dropped word and a dropped last word
		seq.delete();
		for (int i = 0; i < MAX_ITEMS + 2; i++)
			seq.push_back((i < MAX_ITEMS) ? 32'h5A5A_C3C3 : 32'h0000_0001);
		send_sequence(seq);

		target = words_sent + 555;
		while (words_sent < target)
			random_sequence();

		start <= 1'b0;
		while (sb.pending_modes.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (sb.mismatches == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end
endmodule
